// ----- src/hwsm_pkg.sv -----
// ----------------------------------------------------------------------------
// hwsm_pkg - shared constants for the Hall wheel speed meter
// Field widths, register indexes, command codes and reset-derived values.
// ----------------------------------------------------------------------------
package hwsm_pkg;

	// field and register widths
	localparam int unsigned DIAM_W      = 8;
	localparam int unsigned MAG_W       = 7;
	localparam int unsigned MINSP_W     = 16;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned SPEED_W     = 30;
	localparam int unsigned MS_W        = 20;              // 3140 * 255 fits
	localparam int unsigned MAG_SPD_W   = MAG_W + MINSP_W; // magnets * min speed

	localparam int unsigned TIME_BITS_DEF = 30;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIAMETER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAGNETS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 2'd2;

	// commands
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// pi as 314/100, scaled to um/cm-per-us and to ms
	localparam int unsigned PI_NUM       = 314;
	localparam int unsigned PI_DEN       = 100;
	localparam int unsigned NUM_K        = PI_NUM * 1000000 / PI_DEN;
	localparam int unsigned MS_K         = PI_NUM * 1000 / PI_DEN;
	localparam int unsigned TICKS_PER_MS = 1000;

	// register reset values
	localparam int unsigned RST_DIAM      = 6;
	localparam int unsigned RST_MAGNETS   = 2;
	localparam int unsigned RST_MIN_SPEED = 20;

	localparam int unsigned RST_NUMERATOR   = NUM_K * RST_DIAM / RST_MAGNETS;
	localparam int unsigned RST_STALL_TICKS =
		((MS_K * RST_DIAM / RST_MAGNETS) / RST_MIN_SPEED) * TICKS_PER_MS;

endpackage

// ----- src/hwsm_cmd_if.sv -----
// ----------------------------------------------------------------------------
// hwsm_cmd_if - command channel
// Carries tick and read commands with the sampled sensor level.
// ----------------------------------------------------------------------------
interface hwsm_cmd_if;
	logic valid;
	logic ready;
	logic command;
	logic sensor_level;

	modport source (output valid, command, sensor_level, input ready);
	modport sink   (input valid, command, sensor_level, output ready);
endinterface

// ----- src/hwsm_speed_if.sv -----
// ----------------------------------------------------------------------------
// hwsm_speed_if - speed result channel
// Carries one speed word per read command.
// ----------------------------------------------------------------------------
interface hwsm_speed_if;
	logic                         valid;
	logic                         ready;
	logic [hwsm_pkg::SPEED_W-1:0] speed_cm_s;

	modport source (output valid, speed_cm_s, input ready);
	modport sink   (input valid, speed_cm_s, output ready);
endinterface

// ----- src/hall_wheel_speed_meter.sv -----
// ----------------------------------------------------------------------------
// hall_wheel_speed_meter - wheel tachometer with stall timeout
// Period measurement between Hall falling edges, speed by shared divider.
// ----------------------------------------------------------------------------
// Usage:
//  cmd_ch carries one word per command. A tick (command 0) advances time by
//  one microsecond and samples sensor_level; a falling edge marks a magnet.
//  Ticks produce no result. A read (command 1) produces one speed word
//  on speed_ch: numerator / gap in cm/s, or 0 with no gap. A read with a
//  known gap runs the shared divider, one quotient bit per cycle, then hands
//  the quotient to the output register; a read without a gap skips the
//  divider and hands over 0. cmd_ch.ready is low meanwhile.
//  A config write to one of the three registers (cfg_we, cfg_index, cfg_data)
//  recomputes the numerator and the stall time with the same divider, with
//  ready low; a further write restarts the sequence.
//  Reset clears the measurement (no edge, no gap) and loads registers and
//  derived values for diameter 6 cm, 2 magnets, 20 cm/s.
//  A stalled speed_ch holds its word in the output register; the next
//  command is still taken, and a further read waits for that register.
// ----------------------------------------------------------------------------
module hall_wheel_speed_meter #(
	parameter int unsigned TIME_BITS = hwsm_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	hwsm_cmd_if.sink                           cmd_ch,
	hwsm_speed_if.source                       speed_ch,
	input  logic                               cfg_we,
	input  logic [hwsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hwsm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int unsigned SPEED_W = hwsm_pkg::SPEED_W;
	localparam int unsigned DEN_W   =
		(TIME_BITS > hwsm_pkg::MAG_SPD_W) ? TIME_BITS : hwsm_pkg::MAG_SPD_W;
	localparam int unsigned CW      = (TIME_BITS > SPEED_W) ? TIME_BITS : SPEED_W;
	localparam logic [CW-1:0] TMAX_W = CW'((64'd1 << TIME_BITS) - 64'd1);
	localparam logic [TIME_BITS-1:0] STALL_RST = TIME_BITS'(hwsm_pkg::RST_STALL_TICKS);

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RDIV  = 4'd1;  // read: divider running
	localparam logic [3:0] S_RPUT  = 4'd2;  // read: hand word to output reg
	localparam logic [3:0] S_DMUL  = 4'd3;  // derive: register products
	localparam logic [3:0] S_DNUM  = 4'd4;  // derive: start numerator divide
	localparam logic [3:0] S_DNUMW = 4'd5;  // derive: wait numerator divide
	localparam logic [3:0] S_DMSW  = 4'd6;  // derive: wait stall ms divide
	localparam logic [3:0] S_DSCL  = 4'd7;  // derive: ms to ticks
	localparam logic [3:0] S_DCLP  = 4'd8;  // derive: clamp and store

	logic [3:0] state_q;

	// config registers
	logic [hwsm_pkg::DIAM_W-1:0]  diam_q;
	logic [hwsm_pkg::MAG_W-1:0]   mag_q;
	logic [hwsm_pkg::MINSP_W-1:0] minsp_q;

	// derived values
	logic [SPEED_W-1:0]   numer_q;
	logic [TIME_BITS-1:0] stall_q;

	// measurement state
	logic                 prev_level_q;
	logic                 have_edge_q;
	logic                 have_gap_q;
	logic [TIME_BITS-1:0] since_edge_q;
	logic [TIME_BITS-1:0] gap_q;

	// derivation scratch
	logic [SPEED_W-1:0]             num_prod_q;
	logic [hwsm_pkg::MS_W-1:0]      ms_prod_q;
	logic [hwsm_pkg::MAG_SPD_W-1:0] den_prod_q;
	logic [hwsm_pkg::MS_W-1:0]      ms_q;
	logic [SPEED_W-1:0]             stall_prod_q;

	// result path
	logic [SPEED_W-1:0] res_q;
	logic               out_valid_q;
	logic [SPEED_W-1:0] out_q;

	logic               cfg_hit;
	logic               in_acc;
	logic               tick_acc;
	logic               read_acc;
	logic               gap_ok;
	logic               rd_start;
	logic               out_load;

	logic [hwsm_pkg::MAG_W-1:0]   mag_eff;
	logic [hwsm_pkg::MINSP_W-1:0] minsp_eff;

	logic                 since_lt;
	logic [TIME_BITS-1:0] since_inc;
	logic [TIME_BITS-1:0] since_sat;
	logic                 stall_hit;
	logic                 edge_kept;
	logic                 fall;

	logic [CW-1:0]        stall_w;
	logic [TIME_BITS-1:0] stall_clamped;

	logic               div_start;
	logic [SPEED_W-1:0] div_num;
	logic [DEN_W-1:0]   div_den;
	logic               div_done;
	logic [SPEED_W-1:0] div_quo;

	// ---- handshake and decode ------------------------------------------------
	assign cfg_hit = cfg_we && (cfg_index == hwsm_pkg::REG_DIAMETER ||
		cfg_index == hwsm_pkg::REG_MAGNETS || cfg_index == hwsm_pkg::REG_MIN_SPEED);

	// writes take priority over a command in the same cycle
	assign cmd_ch.ready = (state_q == S_IDLE) && !cfg_we;
	assign in_acc       = cmd_ch.valid && cmd_ch.ready;
	assign tick_acc     = in_acc && (cmd_ch.command == hwsm_pkg::CMD_TICK);
	assign read_acc     = in_acc && (cmd_ch.command == hwsm_pkg::CMD_READ);
	assign gap_ok       = have_gap_q && (gap_q != '0);
	assign rd_start     = read_acc && gap_ok;

	assign out_load = (state_q == S_RPUT) && (!out_valid_q || speed_ch.ready);

	// zero magnets or zero min speed count as one
	assign mag_eff   = (mag_q == '0) ? hwsm_pkg::MAG_W'(1) : mag_q;
	assign minsp_eff = (minsp_q == '0) ? hwsm_pkg::MINSP_W'(1) : minsp_q;

	// ---- tick update ---------------------------------------------------------
	// saturating time count; stall checked on the updated count, before edge
	assign since_lt  = since_edge_q < stall_q;
	assign since_inc = since_edge_q + 1'b1;
	assign since_sat = since_lt ? since_inc : stall_q;
	assign stall_hit = have_edge_q && (!since_lt || since_inc == stall_q);
	assign edge_kept = have_edge_q && !stall_hit;
	assign fall      = prev_level_q && !cmd_ch.sensor_level;

	// ---- stall clamp ---------------------------------------------------------
	assign stall_w       = CW'(stall_prod_q);
	assign stall_clamped = (stall_w > TMAX_W) ? TIME_BITS'(TMAX_W) : TIME_BITS'(stall_w);

	// ---- divider operand select ----------------------------------------------
	always_comb begin
		div_start = 1'b0;
		div_num   = numer_q;
		div_den   = DEN_W'(gap_q);
		if (rd_start) begin
			div_start = 1'b1;
		end else if (state_q == S_DNUM) begin
			div_start = 1'b1;
			div_num   = num_prod_q;
			div_den   = DEN_W'(mag_eff);
		end else if (state_q == S_DNUMW && div_done) begin
			div_start = 1'b1;
			div_num   = SPEED_W'(ms_prod_q);
			div_den   = DEN_W'(den_prod_q);
		end
	end

	hwsm_div #(
		.NUM_W (SPEED_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ---- sequencer and state -------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			diam_q       <= hwsm_pkg::DIAM_W'(hwsm_pkg::RST_DIAM);
			mag_q        <= hwsm_pkg::MAG_W'(hwsm_pkg::RST_MAGNETS);
			minsp_q      <= hwsm_pkg::MINSP_W'(hwsm_pkg::RST_MIN_SPEED);
			numer_q      <= SPEED_W'(hwsm_pkg::RST_NUMERATOR);
			stall_q      <= STALL_RST;
			prev_level_q <= 1'b1;
			have_edge_q  <= 1'b0;
			have_gap_q   <= 1'b0;
			since_edge_q <= '0;
			gap_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					hwsm_pkg::REG_DIAMETER:  diam_q  <= cfg_data[hwsm_pkg::DIAM_W-1:0];
					hwsm_pkg::REG_MAGNETS:   mag_q   <= cfg_data[hwsm_pkg::MAG_W-1:0];
					hwsm_pkg::REG_MIN_SPEED: minsp_q <= cfg_data[hwsm_pkg::MINSP_W-1:0];
					default: ;
				endcase
			end

			if (tick_acc) begin
				prev_level_q <= cmd_ch.sensor_level;
				have_edge_q  <= fall || edge_kept;
				since_edge_q <= fall ? '0 : since_sat;
				if (fall && edge_kept) begin
					gap_q      <= since_sat;
					have_gap_q <= 1'b1;
				end else begin
					have_gap_q <= have_gap_q && !stall_hit;
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (speed_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_hit) begin
				state_q <= S_DMUL;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (rd_start) begin
							state_q <= S_RDIV;
						end else if (read_acc) begin
							state_q <= S_RPUT;
						end
					end
					S_RDIV: begin
						if (div_done) begin
							state_q <= S_RPUT;
						end
					end
					S_RPUT: begin
						if (out_load) begin
							state_q <= S_IDLE;
						end
					end
					S_DMUL: state_q <= S_DNUM;
					S_DNUM: state_q <= S_DNUMW;
					S_DNUMW: begin
						if (div_done) begin
							numer_q <= div_quo;
							state_q <= S_DMSW;
						end
					end
					S_DMSW: begin
						if (div_done) begin
							state_q <= S_DSCL;
						end
					end
					S_DSCL: state_q <= S_DCLP;
					S_DCLP: begin
						stall_q <= stall_clamped;
						state_q <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	// ---- datapath registers --------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == S_DMUL) begin
			num_prod_q <= SPEED_W'(hwsm_pkg::NUM_K) * SPEED_W'(diam_q);
			ms_prod_q  <= hwsm_pkg::MS_W'(hwsm_pkg::MS_K) * hwsm_pkg::MS_W'(diam_q);
			den_prod_q <= hwsm_pkg::MAG_SPD_W'(mag_eff) * hwsm_pkg::MAG_SPD_W'(minsp_eff);
		end
		if (state_q == S_DMSW && div_done) begin
			ms_q <= div_quo[hwsm_pkg::MS_W-1:0];
		end
		if (state_q == S_DSCL) begin
			stall_prod_q <= SPEED_W'(ms_q) * SPEED_W'(hwsm_pkg::TICKS_PER_MS);
		end
		if (read_acc && !gap_ok) begin
			res_q <= '0;
		end else if (state_q == S_RDIV && div_done) begin
			res_q <= div_quo;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign speed_ch.valid      = out_valid_q;
	assign speed_ch.speed_cm_s = out_q;

`ifndef SYNTHESIS
	a_gap_needs_edge: assert property (@(posedge clk) disable iff (!arst_n)
		have_gap_q |-> have_edge_q)
		else $error("gap known without a reference edge");
	a_read_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(read_acc && !gap_ok) |=> (state_q == S_RPUT && res_q == '0))
		else $error("read without gap did not return zero");
	a_out_from_put: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RPUT))
		else $error("speed word loaded outside the read sequence");
`endif

endmodule

// ----- src/hwsm_div.sv -----
// ----------------------------------------------------------------------------
// hwsm_div - shared restoring divider
// One quotient bit per cycle; done pulses with the quotient valid.
// ----------------------------------------------------------------------------
module hwsm_div #(
	parameter int unsigned NUM_W = hwsm_pkg::SPEED_W,
	parameter int unsigned DEN_W = hwsm_pkg::TIME_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && cnt_q == '0)
		else $error("divider did not start");
`endif

endmodule

// ----- test/hall_wheel_speed_meter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hall_wheel_speed_meter_tb - self-checking bench for the wheel tachometer
// A directed table (reset state, register extremes, zero divisors, stall
// timing) is followed by randomized phases. Each phase loads new registers,
// then plays magnet pulse trains, stall boundary runs and noise. Speed words
// are checked against an in-bench tachometer predictor. Bursty sender,
// patterned receiver, and a long receiver hold-off to back up the block.
// ----------------------------------------------------------------------------
module hall_wheel_speed_meter_tb;
	import hwsm_pkg::*;

	// index past the register list, written to check that it is ignored
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	localparam int RND_WORDS    = 1200;   // random part stops after this many words
	localparam int MIN_READS    = 48;     // ... and at least this many speed reads
	localparam int SETTLE_CYCLS = 80;     // pause before each register write, covering a register recompute
	localparam int HOLD_CYCLS   = 300;    // long receiver hold-off
	localparam int TAIL_CYCLS   = 100;
	localparam int DRAIN_LIMIT  = 20000;

	typedef enum logic [1:0] {ROW_TICK, ROW_READ, ROW_CFG} row_op_e;

	// one row of the directed table; for ticks and reads val[0] is the level
	typedef struct {
		row_op_e                op;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  val;
		int                     reps;
		bit                     pinned;  // expected speed typed in below
		logic [SPEED_W-1:0]     speed;
	} step_row_t;

	localparam int DIR_ROWS = 43;

	step_row_t dir_tab [DIR_ROWS] = '{
		'{ROW_READ, REG_NONE,      16'd1,    1,   1'b1, 30'd0},          // fresh: no gap
		'{ROW_TICK, REG_NONE,      16'd1,    1,   1'b0, 30'd0},
		'{ROW_TICK, REG_NONE,      16'd0,    1,   1'b0, 30'd0},          // first magnet
		'{ROW_TICK, REG_NONE,      16'd1,    1,   1'b0, 30'd0},
		'{ROW_TICK, REG_NONE,      16'd0,    1,   1'b0, 30'd0},          // shortest gap (2 us)
		'{ROW_READ, REG_NONE,      16'd0,    1,   1'b0, 30'd0},
		'{ROW_CFG,  REG_DIAMETER,  16'hA5FF, 1,   1'b0, 30'd0},          // 255, high byte dropped
		'{ROW_CFG,  REG_MAGNETS,   16'h0001, 1,   1'b0, 30'd0},
		'{ROW_READ, REG_NONE,      16'd1,    1,   1'b1, 30'd400350000},  // gap kept, top speed
		'{ROW_CFG,  REG_MIN_SPEED, 16'hFFFF, 1,   1'b0, 30'd0},
		'{ROW_CFG,  REG_NONE,      16'h5A5A, 1,   1'b0, 30'd0},          // no such register
		'{ROW_READ, REG_NONE,      16'd0,    1,   1'b1, 30'd400350000},
		'{ROW_CFG,  REG_DIAMETER,  16'h0001, 1,   1'b0, 30'd0},
		'{ROW_CFG,  REG_MAGNETS,   16'hFFC0, 1,   1'b0, 30'd0},          // 64 after masking
		'{ROW_CFG,  REG_MIN_SPEED, 16'd50,   1,   1'b0, 30'd0},          // stall time 0
		'{ROW_TICK, REG_NONE,      16'd1,    1,   1'b0, 30'd0},
		'{ROW_TICK, REG_NONE,      16'd0,    1,   1'b0, 30'd0},
		'{ROW_TICK, REG_NONE,      16'd1,    1,   1'b0, 30'd0},
		'{ROW_TICK, REG_NONE,      16'd0,    1,   1'b0, 30'd0},
		'{ROW_READ, REG_NONE,      16'd1,    1,   1'b1, 30'd0},          // stall eats every gap
		'{ROW_CFG,  REG_MAGNETS,   16'hFF80, 1,   1'b0, 30'd0},          // zero magnets
		'{ROW_CFG,  REG_MIN_SPEED, 16'd0,    1,   1'b0, 30'd0},          // zero min speed
		'{ROW_TICK, REG_NONE,      16'd1,    1,   1'b0, 30'd0},
		'{ROW_TICK, REG_NONE,      16'd0,    1,   1'b0, 30'd0},
		'{ROW_TICK, REG_NONE,      16'd1,    1,   1'b0, 30'd0},
		'{ROW_TICK, REG_NONE,      16'd0,    1,   1'b0, 30'd0},
		'{ROW_READ, REG_NONE,      16'd0,    1,   1'b0, 30'd0},
		'{ROW_CFG,  REG_DIAMETER,  16'hFF00, 1,   1'b0, 30'd0},          // zero diameter
		'{ROW_READ, REG_NONE,      16'd1,    1,   1'b1, 30'd0},
		'{ROW_CFG,  REG_DIAMETER,  16'h0001, 1,   1'b0, 30'd0},
		'{ROW_CFG,  REG_MAGNETS,   16'd64,   1,   1'b0, 30'd0},
		'{ROW_CFG,  REG_MIN_SPEED, 16'd49,   1,   1'b0, 30'd0},          // stall time 1000 us
		'{ROW_TICK, REG_NONE,      16'd1,    1,   1'b0, 30'd0},
		'{ROW_TICK, REG_NONE,      16'd0,    1,   1'b0, 30'd0},
		'{ROW_TICK, REG_NONE,      16'd1,    999, 1'b0, 30'd0},
		'{ROW_TICK, REG_NONE,      16'd0,    1,   1'b0, 30'd0},          // stall and magnet together
		'{ROW_READ, REG_NONE,      16'd0,    1,   1'b1, 30'd0},
		'{ROW_TICK, REG_NONE,      16'd1,    1,   1'b0, 30'd0},
		'{ROW_TICK, REG_NONE,      16'd0,    1,   1'b0, 30'd0},
		'{ROW_READ, REG_NONE,      16'd1,    1,   1'b0, 30'd0},
		'{ROW_TICK, REG_NONE,      16'd1,    998, 1'b0, 30'd0},
		'{ROW_TICK, REG_NONE,      16'd0,    1,   1'b0, 30'd0},          // longest gap, 999 us
		'{ROW_READ, REG_NONE,      16'd0,    1,   1'b0, 30'd0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hwsm_cmd_if   cmd_ch ();
	hwsm_speed_if speed_ch ();

	hall_wheel_speed_meter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ch    (cmd_ch),
		.speed_ch  (speed_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Tachometer predictor: registers, derived values, measurement state
	// ------------------------------------------------------------------
	longint unsigned diam_reg  = RST_DIAM;
	longint unsigned mag_reg   = RST_MAGNETS;
	longint unsigned minsp_reg = RST_MIN_SPEED;
	longint unsigned spd_num;      // cm*um/s per magnet gap
	longint unsigned stall_lim;    // us of silence before the wheel counts as stopped
	longint unsigned since_us  = 0;
	longint unsigned gap_len   = 0;
	bit              last_lvl  = 1'b1;   // sensor idles high
	bit              edge_seen = 1'b0;
	bit              gap_known = 1'b0;

	logic [SPEED_W-1:0] speed_due [$];   // speed words still owed by the block

	int  err_cnt    = 0;
	int  words_sent = 0;
	int  reads_sent = 0;
	int  burst_left = 0;
	bit  tx_bursty  = 1'b0;
	int  rx_mode    = 0;
	bit  hold_req   = 1'b0;

	function automatic void recompute_derived();
		longint unsigned mags, floor_sp, ms, lim;
		mags     = (mag_reg == 0) ? 64'd1 : mag_reg;
		floor_sp = (minsp_reg == 0) ? 64'd1 : minsp_reg;
		// pi taken as 314/100, truncated at each step like the hardware
		spd_num  = (64'd314 * 64'd1000000 * diam_reg / 64'd100) / mags;
		ms       = ((64'd314 * 64'd1000 * diam_reg / 64'd100) / mags) / floor_sp;
		lim      = (64'd1 << TIME_BITS_DEF) - 64'd1;
		stall_lim = (ms * 64'd1000 > lim) ? lim : ms * 64'd1000;
	endfunction

	function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
	                                  input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_DIAMETER:  diam_reg  = val[DIAM_W-1:0];
			REG_MAGNETS:   mag_reg   = val[MAG_W-1:0];
			REG_MIN_SPEED: minsp_reg = val[MINSP_W-1:0];
			default: return;
		endcase
		recompute_derived();
	endfunction

	// advance the meter by one word; returns 1 when a speed word is due
	function automatic bit meter_step(input logic cmd, input logic lvl,
	                                  output logic [SPEED_W-1:0] spd);
		spd = '0;
		if (cmd == CMD_READ) begin
			if (gap_known && gap_len != 0)
				spd = spd_num / gap_len;
			return 1'b1;
		end
		// time runs first, saturating at the stall limit
		if (since_us < stall_lim)
			since_us++;
		else
			since_us = stall_lim;
		// stall is checked before the edge, so a late magnet starts afresh
		if (edge_seen && since_us >= stall_lim) begin
			edge_seen = 1'b0;
			gap_known = 1'b0;
		end
		if (last_lvl && !lvl) begin
			if (edge_seen) begin
				gap_len   = since_us;
				gap_known = 1'b1;
			end
			edge_seen = 1'b1;
			since_us  = 0;
		end
		last_lvl = lvl;
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// Command side
	// ------------------------------------------------------------------
	// Drive at the falling edge, wait for the handshake at a rising edge.
	// valid is left high after acceptance; the next call decides at the
	// following falling edge whether it stays high or a gap opens.
	task automatic send_word(input logic cmd, input logic lvl, input bit pinned,
	                         input logic [SPEED_W-1:0] pinned_speed);
		int                 gap;
		logic [SPEED_W-1:0] spd;
		@(negedge clk);
		if (tx_bursty && burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
			burst_left = $urandom_range(1, 16);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		cmd_ch.valid        <= 1'b1;
		cmd_ch.command      <= cmd;
		cmd_ch.sensor_level <= lvl;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		words_sent++;
		if (meter_step(cmd, lvl, spd)) begin
			speed_due.push_back(pinned ? pinned_speed : spd);
			reads_sent++;
		end
	endtask

	task automatic tick_run(input logic lvl, input int n);
		repeat (n) send_word(CMD_TICK, lvl, 1'b0, '0);
	endtask

	task automatic read_speed();
		send_word(CMD_READ, logic'($urandom_range(0, 1)), 1'b0, '0);
	endtask

	// registers change only with the block idle: nothing owed, then a pause
	// long enough for the divider to finish whatever it was doing
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (speed_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLS) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		apply_cfg(idx, val);
	endtask

	// new register set for a phase, leaning toward short stall times
	task automatic pick_setting();
		longint unsigned      d, m, base, sp;
		logic [CFG_IDX_W-1:0] ids [3];
		logic [CFG_DATA_W-1:0] vals [3];
		int                   first;
		d    = $urandom_range(1, 255);
		m    = $urandom_range(1, 127);
		base = (64'd3140 * d) / m;   // stall time in ms at min speed 1
		case ($urandom_range(0, 5))
			0: begin
				d  = RST_DIAM;
				m  = RST_MAGNETS;
				sp = RST_MIN_SPEED;
			end
			1: sp = $urandom_range(0, 65535);
			2: sp = base / $urandom_range(1, 2);              // 1..2 ms stall
			3: sp = (base < 65535) ? $urandom_range(base + 1, 65535) : 65535; // 0 ms
			4: begin
				d  = 255;
				m  = 1;
				sp = $urandom_range(0, 1) ? 1 : 65535;
			end
			default: begin
				// zero diameter / magnets / min speed corners
				d  = $urandom_range(0, 3);
				m  = $urandom_range(0, 2);
				sp = $urandom_range(0, 3) * 1000;
			end
		endcase
		ids[0]  = REG_DIAMETER;
		ids[1]  = REG_MAGNETS;
		ids[2]  = REG_MIN_SPEED;
		// unused upper bits get random garbage; the block must drop them
		vals[0] = {8'($urandom), 8'(d)};
		vals[1] = {9'($urandom), 7'(m)};
		vals[2] = 16'(sp);
		first = $urandom_range(0, 2);
		for (int j = 0; j < 3; j++)
			write_reg(ids[(first + j) % 3], vals[(first + j) % 3]);
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_NONE, 16'($urandom));
	endtask

	// ------------------------------------------------------------------
	// Speed side: receiver stalls, long hold-off on request
	// ------------------------------------------------------------------
	initial begin : rx_side
		int          hold_cnt;
		int          cyc;
		logic [15:0] pat;
		speed_ch.ready = 1'b0;
		cyc = 0;
		pat = 16'hFFFF;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// hold long enough that the output register fills and the
				// block has to refuse the next read
				speed_ch.ready <= 1'b0;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLS; hold_cnt++)
					@(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (cyc % 64 == 0)
					pat = 16'($urandom);
				cyc++;
				case (rx_mode)
					0: speed_ch.ready <= 1'b1;
					1: speed_ch.ready <= pat[cyc % 16];
					default: speed_ch.ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// every accepted speed word is matched against the oldest one owed
	always @(posedge clk) begin : speed_check
		logic [SPEED_W-1:0] want;
		if (speed_ch.valid === 1'b1 && speed_ch.ready === 1'b1) begin
			if (speed_due.size() == 0) begin
				if (err_cnt < 10)
					$display("unexpected speed word: got %0d", speed_ch.speed_cm_s);
				err_cnt++;
			end else begin
				want = speed_due.pop_front();
				if (speed_ch.speed_cm_s !== want) begin
					if (err_cnt < 10)
						$display("speed mismatch: expected %0d, got %0d",
						         want, speed_ch.speed_cm_s);
					err_cnt++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		int              rnd_start, phase, n, h, l, k, w;
		bit              did_boundary;
		cmd_ch.valid        = 1'b0;
		cmd_ch.command      = CMD_TICK;
		cmd_ch.sensor_level = 1'b1;
		cfg_we              = 1'b0;
		cfg_index           = REG_DIAMETER;
		cfg_data            = '0;
		arst_n              = 1'b0;
		recompute_derived();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// directed table, steady handshakes
		foreach (dir_tab[r]) begin
			if (dir_tab[r].op == ROW_CFG)
				write_reg(dir_tab[r].idx, dir_tab[r].val);
			else
				repeat (dir_tab[r].reps)
					send_word((dir_tab[r].op == ROW_READ) ? CMD_READ : CMD_TICK,
					          dir_tab[r].val[0], dir_tab[r].pinned, dir_tab[r].speed);
		end

		// random phases: registers, traffic shape, then a string of events
		rnd_start = words_sent;
		phase = 0;
		while (words_sent - rnd_start < RND_WORDS || reads_sent < MIN_READS) begin
			pick_setting();
			tx_bursty    = ($urandom_range(0, 3) != 0);
			rx_mode      = $urandom_range(0, 2);
			did_boundary = 1'b0;
			if (phase % 5 == 1) begin
				// back-pressure: first word waits in the output register,
				// the second read must stall at the command side
				hold_req = 1'b1;
				read_speed();
				tick_run(1'b1, 3);
				read_speed();
				read_speed();
				tick_run(1'b0, 2);
			end
			n = $urandom_range(10, 30);
			repeat (n) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						// one magnet pass: high run then low run, mostly short
						h = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 200)
						                                : $urandom_range(1, 12);
						l = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 200)
						                                : $urandom_range(1, 12);
						tick_run(1'b1, h);
						tick_run(1'b0, l);
						if ($urandom_range(0, 1))
							read_speed();
					end
					6: begin
						// silence just under, at and just over the stall time
						if (!did_boundary && stall_lim >= 1000 && stall_lim <= 2000) begin
							did_boundary = 1'b1;
							k = int'(stall_lim) - 1 + $urandom_range(0, 2);
							tick_run(1'b1, 1);
							tick_run(1'b0, 1);
							tick_run(1'b1, k - 1);
							tick_run(1'b0, 1);
							read_speed();
						end else begin
							read_speed();
						end
					end
					7: begin
						// noise: random levels, stray reads
						repeat ($urandom_range(1, 8))
							send_word(($urandom_range(0, 3) == 0) ? CMD_READ : CMD_TICK,
							          logic'($urandom_range(0, 1)), 1'b0, '0);
					end
					default: repeat ($urandom_range(1, 3)) read_speed();
				endcase
			end
			phase++;
		end

		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		for (w = 0; w < DRAIN_LIMIT && speed_due.size() != 0; w++)
			@(posedge clk);
		repeat (TAIL_CYCLS) @(posedge clk);
		if (speed_due.size() != 0)
			$display("%0d speed words never arrived", speed_due.size());
		if (err_cnt == 0 && speed_due.size() == 0)
			$display("[hall_wheel_speed_meter] OK");
		else
			$display("[hall_wheel_speed_meter] ERROR");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin : watchdog
		#20_000_000;
		$display("timeout");
		$display("[hall_wheel_speed_meter] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
src/hwsm_pkg.sv
src/hwsm_cmd_if.sv
src/hwsm_speed_if.sv
src/hwsm_div.sv
src/hall_wheel_speed_meter.sv
test/hall_wheel_speed_meter_tb.sv
